// File: rtl/core/cbor_hd_pkg.sv
// shared types, codes and helpers for the cbor head stream decoder
`timescale 1ns / 1ps

package cbor_hd_pkg;

  // queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // register reset value
  localparam logic [3:0] MaxArgBytesReset = 4'd8;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEAD    = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_ADDL  = 3'd1,
    ERR_TOO_WIDE  = 3'd2,
    ERR_TRUNC     = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_e;

  // major types named where they matter
  localparam logic [2:0] MajUint   = 3'd0;
  localparam logic [2:0] MajNint   = 3'd1;
  localparam logic [2:0] MajBstr   = 3'd2;
  localparam logic [2:0] MajTstr   = 3'd3;
  localparam logic [2:0] MajArray  = 3'd4;
  localparam logic [2:0] MajMap    = 3'd5;
  localparam logic [2:0] MajSimple = 3'd7;

  // additional info codes
  localparam logic [4:0] AddlDirectMax = 5'd23;
  localparam logic [4:0] AddlArg1      = 5'd24;
  localparam logic [4:0] AddlArg8      = 5'd27;
  localparam logic [4:0] AddlHalf      = 5'd25;
  localparam logic [4:0] AddlSingle    = 5'd26;
  localparam logic [4:0] AddlIndef     = 5'd31;

  // record handed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  major;
    logic [4:0]  addl;
    logic [63:0] arg;
    logic [7:0]  cbyte;
    logic        clast;
    err_e        err;
  } rec_t;

  // register value clamped to 1..8 bytes
  function automatic logic [3:0] eff_width(input logic [3:0] cfg);
    logic [3:0] w;
    if (cfg == 4'd0) begin
      w = 4'd1;
    end else if (cfg > 4'd8) begin
      w = 4'd8;
    end else begin
      w = cfg;
    end
    return w;
  endfunction

endpackage

// File: rtl/core/cbor_hd_if.sv
// channel interfaces: byte input, result output, register write
`timescale 1ns / 1ps

interface cbor_hd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cbor_hd_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [2:0]         major_code;
  logic [4:0]         additional_info;
  logic [63:0]        argument_value;
  logic signed [63:0] signed_value;
  logic [31:0]        single_float_bits;
  logic               indefinite_flag;
  logic               break_flag;
  logic [7:0]         content_byte;
  logic               content_last;
  logic [2:0]         error_code;

  modport source (
    output valid, output item_kind, output major_code, output additional_info,
    output argument_value, output signed_value, output single_float_bits,
    output indefinite_flag, output break_flag, output content_byte,
    output content_last, output error_code, input ready
  );
  modport sink (
    input valid, input item_kind, input major_code, input additional_info,
    input argument_value, input signed_value, input single_float_bits,
    input indefinite_flag, input break_flag, input content_byte,
    input content_last, input error_code, output ready
  );
endinterface

interface cbor_hd_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] max_argument_bytes;

  modport source (output valid, output max_argument_bytes, input ready);
  modport sink   (input valid, input max_argument_bytes, output ready);
endinterface

// File: rtl/core/cbor_hd_front.sv
// front end: byte parser that gathers heads and content and emits records
`timescale 1ns / 1ps

module cbor_hd_front
  import cbor_hd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cbor_hd_byte_if.sink data_i,
  input  logic [3:0]  eff_width_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output rec_t        push_data_o
);

  typedef enum logic [1:0] {
    PH_HEAD    = 2'd0,
    PH_ARG     = 2'd1,
    PH_CONTENT = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  major_q, major_d;
  logic [4:0]  addl_q, addl_d;
  logic [3:0]  left_q, left_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] cleft_q, cleft_d;

  logic accept;

  // a byte is taken whenever the queue has room
  assign data_i.ready = !queue_full_i;
  assign accept       = data_i.valid && data_i.ready;

  // parse one byte
  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic [63:0] acc_n;
    logic [3:0]  left_n;
    logic [3:0]  len;
    logic        do_fin;
    logic        do_err;
    logic        do_out;
    err_e        err_code;
    logic [63:0] fin_acc;
    logic        final_byte;

    b          = data_i.data_byte;
    last       = data_i.last_byte;
    phase_d    = phase_q;
    major_d    = major_q;
    addl_d     = addl_q;
    left_d     = left_q;
    acc_d      = acc_q;
    cleft_d    = cleft_q;
    do_fin     = 1'b0;
    do_err     = 1'b0;
    do_out     = 1'b0;
    err_code   = ERR_NONE;
    fin_acc    = '0;
    acc_n      = {acc_q[55:0], b};
    left_n     = left_q - 4'd1;
    len        = 4'd1 << b[1:0];
    final_byte = (cleft_q <= 64'd1);
    push_data_o       = '0;
    push_data_o.major = major_q;
    push_data_o.addl  = addl_q;

    if (accept) begin
      unique case (phase_q)
        PH_ARG: begin
          acc_d  = acc_n;
          left_d = left_n;
          if (left_n == 4'd0) begin
            do_fin  = 1'b1;
            fin_acc = acc_n;
          end else if (last) begin
            do_err   = 1'b1;
            err_code = ERR_TRUNC;
          end
        end
        PH_CONTENT: begin
          if (last && !final_byte) begin
            do_err   = 1'b1;
            err_code = ERR_TRUNC;
          end else begin
            do_out             = 1'b1;
            push_data_o.kind   = KIND_CONTENT;
            push_data_o.cbyte  = b;
            push_data_o.clast  = final_byte;
            if (final_byte) begin
              cleft_d = '0;
              phase_d = PH_HEAD;
            end else begin
              cleft_d = cleft_q - 64'd1;
            end
          end
        end
        default: begin
          // head byte
          major_d           = b[7:5];
          addl_d            = b[4:0];
          push_data_o.major = b[7:5];
          push_data_o.addl  = b[4:0];
          acc_d             = '0;
          left_d            = '0;
          cleft_d           = '0;
          if (b[4:0] <= AddlDirectMax) begin
            acc_d   = {59'd0, b[4:0]};
            do_fin  = 1'b1;
            fin_acc = {59'd0, b[4:0]};
          end else if (b[4:0] <= AddlArg8) begin
            if (len > eff_width_i) begin
              do_err   = 1'b1;
              err_code = ERR_TOO_WIDE;
            end else if (last) begin
              do_err   = 1'b1;
              err_code = ERR_TRUNC;
            end else begin
              left_d  = len;
              phase_d = PH_ARG;
            end
          end else if (b[4:0] == AddlIndef &&
                       (b[7:5] == MajArray || b[7:5] == MajMap ||
                        b[7:5] == MajSimple)) begin
            do_out           = 1'b1;
            push_data_o.kind = KIND_HEAD;
            phase_d          = PH_HEAD;
          end else begin
            do_err   = 1'b1;
            err_code = ERR_BAD_ADDL;
          end
        end
      endcase
    end

    // completed head: strings with a length go on to content
    if (do_fin) begin
      do_out           = 1'b1;
      push_data_o.kind = KIND_HEAD;
      push_data_o.arg  = fin_acc;
      phase_d          = PH_HEAD;
      if ((push_data_o.major == MajBstr || push_data_o.major == MajTstr) &&
          fin_acc != 64'd0) begin
        if (last) begin
          do_err   = 1'b1;
          err_code = ERR_TRUNC;
        end else begin
          phase_d = PH_CONTENT;
          cleft_d = fin_acc;
        end
      end
    end

    // error replaces anything else and restarts at a head byte
    if (do_err) begin
      push_data_o.kind  = KIND_ERROR;
      push_data_o.arg   = '0;
      push_data_o.cbyte = '0;
      push_data_o.clast = 1'b0;
      push_data_o.err   = err_code;
      phase_d           = PH_HEAD;
      left_d            = '0;
      cleft_d           = '0;
    end

    push_o = do_out || do_err;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      major_q <= '0;
      addl_q  <= '0;
      left_q  <= '0;
      acc_q   <= '0;
      cleft_q <= '0;
    end else begin
      phase_q <= phase_d;
      major_q <= major_d;
      addl_q  <= addl_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      cleft_q <= cleft_d;
    end
  end

endmodule

// File: rtl/core/cbor_hd_fifo.sv
// short record queue between front and back
`timescale 1ns / 1ps

module cbor_hd_fifo
  import cbor_hd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t pop_data_o
);

  rec_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o     = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer wrap at the queue depth
  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    logic [QueuePtrW-1:0] r;
    if (p == QueuePtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + QueuePtrW'(1);
    end
    return r;
  endfunction

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/cbor_hd_back.sv
// back end: range check, sign mapping, half widening and output register
`timescale 1ns / 1ps

module cbor_hd_back
  import cbor_hd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [3:0]   eff_width_i,
  input  logic         empty_i,
  input  rec_t         rec_i,
  output logic         pop_o,
  cbor_hd_res_if.source res_o
);

  logic               valid_q;
  kind_e              kind_q, kind_d;
  logic [2:0]         major_q;
  logic [4:0]         addl_q;
  logic [63:0]        arg_q, arg_d;
  logic signed [63:0] sval_q, sval_d;
  logic [31:0]        fbits_q, fbits_d;
  logic               indef_q, indef_d;
  logic               brk_q, brk_d;
  logic [7:0]         cbyte_q;
  logic               clast_q;
  err_e               err_q, err_d;
  logic               overflow;

  // half float to single bits, subnormals normalized
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  expo;
    logic [9:0]  mant;
    logic [3:0]  p;
    logic [7:0]  e32;
    logic [23:0] sh;
    logic [22:0] m32;
    expo = h[14:10];
    mant = h[9:0];
    p    = '0;
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) begin
        p = 4'(i);
      end
    end
    sh = 24'(mant) << (5'd23 - 5'(p));
    if (expo == 5'd0 && mant != 10'd0) begin
      e32 = 8'(p) + 8'd103;
      m32 = sh[22:0];
    end else begin
      if (expo == 5'd0) begin
        e32 = 8'd0;
      end else if (expo == 5'h1F) begin
        e32 = 8'hFF;
      end else begin
        e32 = 8'(expo) + 8'd112;
      end
      m32 = {mant, 13'd0};
    end
    return {h[15], e32, m32};
  endfunction

  // sign bit of the configured width or above set
  always_comb begin
    unique case (eff_width_i)
      4'd1:    overflow = |rec_i.arg[63:7];
      4'd2:    overflow = |rec_i.arg[63:15];
      4'd3:    overflow = |rec_i.arg[63:23];
      4'd4:    overflow = |rec_i.arg[63:31];
      4'd5:    overflow = |rec_i.arg[63:39];
      4'd6:    overflow = |rec_i.arg[63:47];
      4'd7:    overflow = |rec_i.arg[63:55];
      default: overflow = rec_i.arg[63];
    endcase
  end

  assign pop_o = !empty_i && (!valid_q || res_o.ready);

  // finish the record
  always_comb begin
    kind_d  = rec_i.kind;
    arg_d   = rec_i.arg;
    sval_d  = '0;
    fbits_d = '0;
    indef_d = 1'b0;
    brk_d   = 1'b0;
    err_d   = rec_i.err;
    if (rec_i.kind == KIND_HEAD) begin
      if (rec_i.major == MajUint || rec_i.major == MajNint) begin
        if (overflow) begin
          kind_d = KIND_ERROR;
          arg_d  = '0;
          err_d  = ERR_OVERFLOW;
        end else begin
          sval_d = (rec_i.major == MajUint) ? signed'(rec_i.arg) : signed'(~rec_i.arg);
        end
      end else if (rec_i.major == MajSimple) begin
        if (rec_i.addl == AddlHalf) begin
          fbits_d = half_to_single(rec_i.arg[15:0]);
        end else if (rec_i.addl == AddlSingle) begin
          fbits_d = rec_i.arg[31:0];
        end else if (rec_i.addl == AddlIndef) begin
          brk_d = 1'b1;
        end
      end else if (rec_i.addl == AddlIndef) begin
        indef_d = 1'b1;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= kind_d;
      major_q <= rec_i.major;
      addl_q  <= rec_i.addl;
      arg_q   <= arg_d;
      sval_q  <= sval_d;
      fbits_q <= fbits_d;
      indef_q <= indef_d;
      brk_q   <= brk_d;
      cbyte_q <= rec_i.cbyte;
      clast_q <= rec_i.clast;
      err_q   <= err_d;
    end
  end

  assign res_o.valid             = valid_q;
  assign res_o.item_kind         = kind_q;
  assign res_o.major_code        = major_q;
  assign res_o.additional_info   = addl_q;
  assign res_o.argument_value    = arg_q;
  assign res_o.signed_value      = sval_q;
  assign res_o.single_float_bits = fbits_q;
  assign res_o.indefinite_flag   = indef_q;
  assign res_o.break_flag        = brk_q;
  assign res_o.content_byte      = cbyte_q;
  assign res_o.content_last      = clast_q;
  assign res_o.error_code        = err_q;

endmodule

// File: rtl/core/cbor_head_stream_decoder.sv
// top level of the cbor data item head stream decoder
//
// data_i takes one payload byte per transfer with last_byte marking the end
// of the buffer; res_o gives zero or one result per byte: a decoded head, a
// string content byte, or an error. cfg_i writes max_argument_bytes (reset 8)
// and is always ready; write it only while no byte is in flight.
// Throughput: one byte per cycle while the record queue has room; the parser
// state in the front end updates its accumulator and counters for each byte.
// The record for the byte that completes a result is written into the record
// queue at the transfer of that byte and moves on into the output register once
// the output register is free. Bytes that only gather argument bits give no result.
// When res_o stalls, the two-entry queue and the output register absorb up
// to three results before data_i.ready drops; nothing is lost or repeated.
// Reset clears the parser to expect a head byte, empties the queue and the
// output register, and sets max_argument_bytes to 8.
`timescale 1ns / 1ps

module cbor_head_stream_decoder
  import cbor_hd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  cbor_hd_byte_if.sink  data_i,
  cbor_hd_cfg_if.sink   cfg_i,
  cbor_hd_res_if.source res_o
);

  logic [3:0] cfg_q;
  logic [3:0] eff_w;
  logic       rec_push;
  rec_t       rec_in;
  logic       queue_full;
  logic       queue_empty;
  logic       rec_pop;
  rec_t       rec_out;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= MaxArgBytesReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      cfg_q <= cfg_i.max_argument_bytes;
    end
  end

  assign eff_w = eff_width(cfg_q);

  // byte parser
  cbor_hd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_i       (data_i),
    .eff_width_i  (eff_w),
    .queue_full_i (queue_full),
    .push_o       (rec_push),
    .push_data_o  (rec_in)
  );

  // record queue
  cbor_hd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rec_push),
    .push_data_i (rec_in),
    .full_o      (queue_full),
    .pop_i       (rec_pop),
    .empty_o     (queue_empty),
    .pop_data_o  (rec_out)
  );

  // result formatter
  cbor_hd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_width_i (eff_w),
    .empty_i     (queue_empty),
    .rec_i       (rec_out),
    .pop_o       (rec_pop),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  // front never produces a record into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> !queue_full)
    else $error("record pushed into full queue");

  // an error result always carries a code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item_kind == KIND_ERROR) |-> (res_o.error_code != ERR_NONE))
    else $error("error result without code");

  // content fields stay clear outside content results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item_kind != KIND_CONTENT) |->
      (res_o.content_byte == 8'd0 && !res_o.content_last))
    else $error("content fields set on non-content result");

  // a popped record shows up at the output on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop |=> res_o.valid)
    else $error("popped record not presented");
`endif

endmodule
